/* rtl/core/fcc_pkg.sv */
package fcc_pkg;

    // frame layout and limits
    localparam int unsigned HEADER_BYTES    = 4;
    localparam int unsigned MAX_FRAME_BYTES = 1024;
    localparam int unsigned COUNT_W         = 11;
    localparam int unsigned PLEN_W          = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'd2047;
    localparam logic [PLEN_W-1:0]  PAYLOAD_MAX     = 10'd1020;
    localparam logic [COUNT_W-1:0] LIMIT_LOW       = COUNT_W'(HEADER_BYTES);
    localparam logic [COUNT_W-1:0] LIMIT_HIGH      = COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] MAX_LEN_DEFAULT = 11'd256;

    // header byte positions
    localparam logic [COUNT_W-1:0] POS_ID_LO  = 11'd0;
    localparam logic [COUNT_W-1:0] POS_ID_HI  = 11'd1;
    localparam logic [COUNT_W-1:0] POS_CRC_LO = 11'd2;
    localparam logic [COUNT_W-1:0] POS_CRC_HI = 11'd3;

    localparam logic [15:0] CRC_POLY = 16'h8D95;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_LEN_ERR   = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       frame_id;
        logic [15:0]       stored_crc;
        logic [15:0]       computed_crc;
        logic [PLEN_W-1:0] payload_length;
    } result_t;

    // one byte of crc-16, msb first, polynomial 0x8d95
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = {crc[15:8] ^ b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (x[15]) begin
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                x = {x[14:0], 1'b0};
            end
        end
        return {crc[7:0], 8'h00} ^ x;
    endfunction

endpackage

/* rtl/core/fcc_in_reg.sv */
module fcc_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcc_pkg::in_beat_t s_data,
    input  logic              take,
    output logic              beat_valid,
    output fcc_pkg::in_beat_t beat
);
    import fcc_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    // slot frees when the held beat is consumed this cycle
    assign s_ready    = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_data;
        end
    end

endmodule

/* rtl/core/fcc_frame.sv */
module fcc_frame (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          beat_valid,
    input  fcc_pkg::in_beat_t             beat,
    input  logic [fcc_pkg::COUNT_W-1:0]   max_frame_len,
    input  logic                          out_free,
    output logic                          take,
    output logic                          result_load,
    output fcc_pkg::result_t              result
);
    import fcc_pkg::*;

    logic [15:0]        crc_accum_reg,   crc_accum_next;
    logic [COUNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [15:0]        id_capture_reg,  id_capture_next;
    logic [15:0]        crc_capture_reg, crc_capture_next;
    logic               overflow_reg,    overflow_next;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] plen_full;
    logic [PLEN_W-1:0]  plen;

    // a last beat waits for room in the result register
    assign take        = beat_valid && (!beat.last_byte || out_free);
    assign result_load = take && beat.last_byte;

    // clamp the configured limit
    always_comb begin
        if (max_frame_len < LIMIT_LOW) begin
            limit = LIMIT_LOW;
        end else if (max_frame_len > LIMIT_HIGH) begin
            limit = LIMIT_HIGH;
        end else begin
            limit = max_frame_len;
        end
    end

    // header capture, payload crc and length tracking
    always_comb begin
        id_capture_next  = id_capture_reg;
        crc_capture_next = crc_capture_reg;
        crc_accum_next   = crc_accum_reg;
        if (byte_count_reg == POS_ID_LO) begin
            id_capture_next[7:0] = beat.byte_value;
        end else if (byte_count_reg == POS_ID_HI) begin
            id_capture_next[15:8] = beat.byte_value;
        end else if (byte_count_reg == POS_CRC_LO) begin
            crc_capture_next[7:0] = beat.byte_value;
        end else if (byte_count_reg == POS_CRC_HI) begin
            crc_capture_next[15:8] = beat.byte_value;
        end else begin
            crc_accum_next = crc16_byte(crc_accum_reg, beat.byte_value);
        end
        total           = (byte_count_reg == COUNT_MAX) ? COUNT_MAX : byte_count_reg + 11'd1;
        byte_count_next = total;
        overflow_next   = overflow_reg || (total > limit);
    end

    // result fields from the updated frame state
    always_comb begin
        plen_full = total - LIMIT_LOW;
        if (total < LIMIT_LOW) begin
            plen = '0;
        end else if (plen_full > COUNT_W'(PAYLOAD_MAX)) begin
            plen = PAYLOAD_MAX;
        end else begin
            plen = plen_full[PLEN_W-1:0];
        end
        result.frame_id       = id_capture_next;
        result.stored_crc     = crc_capture_next;
        result.computed_crc   = crc_accum_next;
        result.payload_length = plen;
        if (total < LIMIT_LOW || overflow_next) begin
            result.status = STATUS_LEN_ERR;
        end else if (crc_accum_next != crc_capture_next) begin
            result.status = STATUS_CRC_ERR;
        end else begin
            result.status = STATUS_OK;
        end
    end

    // frame state, cleared after each last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_accum_reg   <= '0;
            byte_count_reg  <= '0;
            id_capture_reg  <= '0;
            crc_capture_reg <= '0;
            overflow_reg    <= 1'b0;
        end else if (take) begin
            if (beat.last_byte) begin
                crc_accum_reg   <= '0;
                byte_count_reg  <= '0;
                id_capture_reg  <= '0;
                crc_capture_reg <= '0;
                overflow_reg    <= 1'b0;
            end else begin
                crc_accum_reg   <= crc_accum_next;
                byte_count_reg  <= byte_count_next;
                id_capture_reg  <= id_capture_next;
                crc_capture_reg <= crc_capture_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

endmodule

/* rtl/core/fcc_out_reg.sv */
module fcc_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  fcc_pkg::result_t result,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output fcc_pkg::result_t m_data
);
    import fcc_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

/* rtl/core/frame_crc16_checker.sv */
// a result beat is loaded into the result register when the last byte of its frame is taken
// throughput: one byte per cycle, apart from the stall below; the crc update, header capture and count for a byte
// are computed combinationally between the input register and the result register
// a last byte stalls only while the result register holds a beat not yet taken
// reset (aresetn, synchronous, active low) clears the frame state and both valid
// flags, and sets the frame length limit to 256
module frame_crc16_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fcc_pkg::in_beat_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fcc_pkg::result_t            m_data,
    input  logic                        cfg_wr_en,
    input  logic [fcc_pkg::COUNT_W-1:0] cfg_wr_data
);
    import fcc_pkg::*;

    logic [COUNT_W-1:0] max_frame_len_reg;
    logic               beat_valid;
    in_beat_t           beat;
    logic               take;
    logic               result_load;
    result_t            result;
    logic               out_free;

    // frame length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg <= MAX_LEN_DEFAULT;
        end else if (cfg_wr_en) begin
            max_frame_len_reg <= cfg_wr_data;
        end
    end

    fcc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    fcc_frame u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .max_frame_len (max_frame_len_reg),
        .out_free      (out_free),
        .take          (take),
        .result_load   (result_load),
        .result        (result)
    );

    fcc_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (result_load),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
